### rtl/dcm_pkg.sv
package dcm_pkg;

   localparam int RateWidth = 32;
   localparam int TimeWidth = 32;
   localparam int OutWidth  = 32;
   localparam logic [TimeWidth-1:0] StepTimeReset = 32'd21474836;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_ANGLE = 9'b000000010,
      ST_ROT   = 9'b000000100,
      ST_ERR   = 9'b000001000,
      ST_ORTH  = 9'b000010000,
      ST_SQ    = 9'b000100000,
      ST_SCALE = 9'b001000000,
      ST_MUL   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   // request to the shared multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic add;
      logic sub;
      logic last;
   } mac_ctl_type;

endpackage

### rtl/dcm_if.sv
interface dcm_req_if;
   logic        valid;
   logic        ready;
   logic signed [dcm_pkg::RateWidth-1:0] rate_x;
   logic signed [dcm_pkg::RateWidth-1:0] rate_y;
   logic signed [dcm_pkg::RateWidth-1:0] rate_z;
   modport source (output valid, rate_x, rate_y, rate_z, input ready);
   modport sink   (input valid, rate_x, rate_y, rate_z, output ready);
endinterface

interface dcm_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [dcm_pkg::OutWidth-1:0] elem_00, elem_01, elem_02;
   logic signed [dcm_pkg::OutWidth-1:0] elem_10, elem_11, elem_12;
   logic signed [dcm_pkg::OutWidth-1:0] elem_20, elem_21, elem_22;
   modport source (output valid, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
                   elem_20, elem_21, elem_22, input ready);
   modport sink   (input valid, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
                   elem_20, elem_21, elem_22, output ready);
endinterface

interface dcm_csr_if;
   logic        valid;
   logic        ready;
   logic [dcm_pkg::TimeWidth-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/dcm_mac.sv
// shared multiply-accumulate unit: one product registered, then accumulated
// acc_valid rises once the term marked last is in the accumulator
module dcm_mac #(
   parameter int OpWidth  = 33,
   parameter int AccWidth = 70
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  dcm_pkg::mac_ctl_type       ctl,
   input  logic signed [OpWidth-1:0]  op_a,
   input  logic signed [OpWidth-1:0]  op_b,
   output logic signed [AccWidth-1:0] acc,
   output logic                       acc_valid
);
   logic signed [2*OpWidth-1:0] prod_ff, prod_in;
   dcm_pkg::mac_ctl_type        ctl_ff;
   logic                        go_ff;
   logic                        done_ff;
   logic signed [AccWidth-1:0]  acc_ff, acc_in, base;

   assign prod_in = op_a * op_b;

   always_comb begin
      base = ctl_ff.clear ? '0 : acc_ff;
      acc_in = base;
      if (ctl_ff.add)
         acc_in = base + AccWidth'(prod_ff);
      else if (ctl_ff.sub)
         acc_in = base - AccWidth'(prod_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ctl_ff  <= ctl;
      if (reset) begin
         go_ff   <= 1'b0;
         done_ff <= 1'b0;
         acc_ff  <= '0;
      end else begin
         go_ff   <= go;
         done_ff <= go_ff && ctl_ff.last;
         if (go_ff) acc_ff <= acc_in;
      end
   end

   assign acc       = acc_ff;
   assign acc_valid = done_ff;
endmodule

### rtl/dcm_attitude_update.sv
// rsp.valid rises after a rate transaction is accepted, once the shared multiplier
// has formed 69 products in 34 sums, each sum passing the product and accumulate
// stages, with the scale factor formed once per row
// a new transaction is taken only after the result has been taken, so a result
// stall holds off the next transaction
// reset: synchronous, clears control, restores identity matrix and step_time
module dcm_attitude_update #(
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   dcm_req_if.sink   req,
   dcm_rsp_if.source rsp,
   dcm_csr_if.sink   csr
);
   localparam int W      = ELEMENT_WIDTH;
   localparam int Frac   = W - 3;
   localparam int OpW    = (W > dcm_pkg::TimeWidth ? W : dcm_pkg::TimeWidth) + 1;
   localparam int AccW   = 2 * OpW + 4;
   localparam int AngSh  = 57 - Frac;
   localparam logic signed [W-1:0] One  = W'(1) <<< Frac;
   localparam logic signed [W-1:0] EMax = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] EMin = {1'b1, {(W-1){1'b0}}};

   typedef logic signed [W-1:0] elem_type;

   // round half up by sh bits and saturate to element format
   function automatic elem_type narrow(input logic signed [AccW-1:0] v, input int sh);
      logic signed [AccW-1:0] r;
      begin
         r = (v + (AccW'(1) <<< (sh - 1))) >>> sh;
         if (r > AccW'(EMax))      narrow = EMax;
         else if (r < AccW'(EMin)) narrow = EMin;
         else                      narrow = r[W-1:0];
      end
   endfunction

   // negation that saturates the most negative value
   function automatic elem_type sat_neg(input elem_type a);
      if (a == EMin) return EMax;
      return -a;
   endfunction

   // flat row-major index of row r, column c
   function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
      return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
   endfunction

   dcm_pkg::state_type state_ff;
   logic [dcm_pkg::TimeWidth-1:0] step_ff;
   elem_type mat_ff [9];
   elem_type rot_ff [9];
   elem_type orth_ff [6];   // new x and y rows until both are done
   elem_type ang_ff [3];
   elem_type kin [9];       // small-rotation matrix
   logic signed [dcm_pkg::RateWidth-1:0] rate_ff [3];
   elem_type herr_ff, scale_ff, sq_ff;
   logic [1:0] row_ff;      // element row
   logic [1:0] col_ff;      // element column, or axis for the angles
   logic [1:0] k_ff;        // term within a sum
   logic       wait_ff;     // last term issued, waiting for the sum
   logic       go;
   logic       done;
   logic       sub_term;
   dcm_pkg::mac_ctl_type ctl;
   logic signed [OpW-1:0] op_a, op_b;
   logic signed [AccW-1:0] acc;
   logic acc_valid;
   logic [1:0] last_k;
   logic [3:0] cur;
   elem_type   res_frac;
   elem_type   scale_in;

   dcm_mac #(.OpWidth(OpW), .AccWidth(AccW)) u_mac (
      .clock, .reset, .go, .ctl, .op_a, .op_b, .acc, .acc_valid
   );

   assign cur      = idx3(row_ff, col_ff);
   assign res_frac = narrow(acc, Frac);

   // small-rotation matrix straight from the angles, negations saturate
   always_comb begin
      kin[0] = One;
      kin[1] = sat_neg(ang_ff[2]);
      kin[2] = ang_ff[1];
      kin[3] = ang_ff[2];
      kin[4] = One;
      kin[5] = sat_neg(ang_ff[0]);
      kin[6] = sat_neg(ang_ff[1]);
      kin[7] = ang_ff[0];
      kin[8] = One;
   end

   // operand selection per phase and term
   always_comb begin
      op_a = '0; op_b = '0; last_k = 2'd2;
      case (state_ff)
         dcm_pkg::ST_ANGLE: begin
            last_k = 2'd0;
            op_a = OpW'(rate_ff[col_ff]);
            op_b = OpW'({1'b0, step_ff});
         end
         dcm_pkg::ST_ROT: begin
            op_a = OpW'(mat_ff[idx3(row_ff, k_ff)]);
            op_b = OpW'(kin[idx3(k_ff, col_ff)]);
         end
         dcm_pkg::ST_ERR: begin
            op_a = OpW'(rot_ff[idx3(2'd0, k_ff)]);
            op_b = OpW'(rot_ff[idx3(2'd1, k_ff)]);
         end
         dcm_pkg::ST_ORTH: begin
            last_k = 2'd1;
            if (row_ff != 2'd2) begin
               // rows x, y: r*one - herr*other row
               if (k_ff == 2'd0) begin
                  op_a = OpW'(rot_ff[cur]);
                  op_b = OpW'(One);
               end else begin
                  op_a = OpW'(herr_ff);
                  op_b = OpW'(rot_ff[idx3({1'b0, ~row_ff[0]}, col_ff)]);
               end
            end else begin
               // cross product of rows already written back
               case (col_ff)
                  2'd0: begin
                     op_a = OpW'(k_ff == 2'd0 ? rot_ff[1] : rot_ff[2]);
                     op_b = OpW'(k_ff == 2'd0 ? rot_ff[5] : rot_ff[4]);
                  end
                  2'd1: begin
                     op_a = OpW'(k_ff == 2'd0 ? rot_ff[2] : rot_ff[0]);
                     op_b = OpW'(k_ff == 2'd0 ? rot_ff[3] : rot_ff[5]);
                  end
                  default: begin
                     op_a = OpW'(k_ff == 2'd0 ? rot_ff[0] : rot_ff[1]);
                     op_b = OpW'(k_ff == 2'd0 ? rot_ff[4] : rot_ff[3]);
                  end
               endcase
            end
         end
         dcm_pkg::ST_SQ: begin
            op_a = OpW'(rot_ff[idx3(row_ff, k_ff)]);
            op_b = op_a;
         end
         dcm_pkg::ST_MUL: begin
            last_k = 2'd0;
            op_a = OpW'(rot_ff[cur]);
            op_b = OpW'(scale_ff);
         end
         default: ;
      endcase
   end

   // second term of an orthogonalisation or cross product is subtracted
   assign sub_term = (state_ff == dcm_pkg::ST_ORTH) && (k_ff != 2'd0);
   assign ctl = '{clear: (k_ff == 2'd0), add: !sub_term, sub: sub_term,
                  last: (k_ff == last_k)};

   assign go = !wait_ff && (state_ff inside {dcm_pkg::ST_ANGLE, dcm_pkg::ST_ROT,
                                             dcm_pkg::ST_ERR, dcm_pkg::ST_ORTH,
                                             dcm_pkg::ST_SQ, dcm_pkg::ST_MUL});
   assign done = acc_valid && wait_ff;

   // scale = (3 - sq) / 2 rounded, saturated
   assign scale_in = narrow(AccW'(3) * AccW'(One) - AccW'(sq_ff), 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcm_pkg::ST_IDLE;
         step_ff  <= dcm_pkg::StepTimeReset;
         row_ff   <= '0;
         col_ff   <= '0;
         k_ff     <= '0;
         wait_ff  <= 1'b0;
         for (int i = 0; i < 9; i++) mat_ff[i] <= (i % 4 == 0) ? One : '0;
      end else begin
         if (csr.valid && csr.ready) step_ff <= csr.data;
         // term sequencing, shared by every multiplier phase
         if (go) begin
            if (k_ff == last_k) begin
               k_ff <= '0; wait_ff <= 1'b1;
            end else k_ff <= k_ff + 2'd1;
         end
         if (done) wait_ff <= 1'b0;
         case (state_ff)
            dcm_pkg::ST_IDLE: begin
               if (req.valid) begin
                  rate_ff[0] <= req.rate_x;
                  rate_ff[1] <= req.rate_y;
                  rate_ff[2] <= req.rate_z;
                  row_ff <= '0; col_ff <= '0;
                  state_ff <= dcm_pkg::ST_ANGLE;
               end
            end
            dcm_pkg::ST_ANGLE: if (done) begin
               ang_ff[col_ff] <= narrow(acc, AngSh);
               if (col_ff == 2'd2) begin
                  col_ff <= '0; state_ff <= dcm_pkg::ST_ROT;
               end else col_ff <= col_ff + 2'd1;
            end
            dcm_pkg::ST_ROT: if (done) begin
               rot_ff[cur] <= res_frac;
               if (col_ff == 2'd2) begin
                  col_ff <= '0;
                  if (row_ff == 2'd2) begin
                     row_ff <= '0; state_ff <= dcm_pkg::ST_ERR;
                  end else row_ff <= row_ff + 2'd1;
               end else col_ff <= col_ff + 2'd1;
            end
            dcm_pkg::ST_ERR: if (done) begin
               herr_ff <= narrow(acc, Frac + 1);
               state_ff <= dcm_pkg::ST_ORTH;
            end
            dcm_pkg::ST_ORTH: if (done) begin
               // rows x, y held aside until both are done
               if (row_ff == 2'd2) rot_ff[cur] <= res_frac;
               else orth_ff[cur[2:0]] <= res_frac;
               if (row_ff == 2'd1 && col_ff == 2'd2)
                  for (int i = 0; i < 6; i++)
                     rot_ff[i] <= (i == 5) ? res_frac : orth_ff[i];
               if (col_ff == 2'd2) begin
                  col_ff <= '0;
                  if (row_ff == 2'd2) begin
                     row_ff <= '0; state_ff <= dcm_pkg::ST_SQ;
                  end else row_ff <= row_ff + 2'd1;
               end else col_ff <= col_ff + 2'd1;
            end
            dcm_pkg::ST_SQ: if (done) begin
               sq_ff <= res_frac;
               state_ff <= dcm_pkg::ST_SCALE;
            end
            dcm_pkg::ST_SCALE: begin
               scale_ff <= scale_in;
               state_ff <= dcm_pkg::ST_MUL;
            end
            dcm_pkg::ST_MUL: if (done) begin
               mat_ff[cur] <= res_frac;
               if (col_ff == 2'd2) begin
                  col_ff <= '0;
                  if (row_ff == 2'd2) begin
                     row_ff <= '0; state_ff <= dcm_pkg::ST_OUT;
                  end else begin
                     row_ff <= row_ff + 2'd1; state_ff <= dcm_pkg::ST_SQ;
                  end
               end else col_ff <= col_ff + 2'd1;
            end
            dcm_pkg::ST_OUT: if (rsp.ready) state_ff <= dcm_pkg::ST_IDLE;
            default: state_ff <= dcm_pkg::ST_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == dcm_pkg::ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == dcm_pkg::ST_OUT);
   assign rsp.elem_00 = dcm_pkg::OutWidth'(mat_ff[0]);
   assign rsp.elem_01 = dcm_pkg::OutWidth'(mat_ff[1]);
   assign rsp.elem_02 = dcm_pkg::OutWidth'(mat_ff[2]);
   assign rsp.elem_10 = dcm_pkg::OutWidth'(mat_ff[3]);
   assign rsp.elem_11 = dcm_pkg::OutWidth'(mat_ff[4]);
   assign rsp.elem_12 = dcm_pkg::OutWidth'(mat_ff[5]);
   assign rsp.elem_20 = dcm_pkg::OutWidth'(mat_ff[6]);
   assign rsp.elem_21 = dcm_pkg::OutWidth'(mat_ff[7]);
   assign rsp.elem_22 = dcm_pkg::OutWidth'(mat_ff[8]);

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready) else $error("accepted while busy");
   a_out: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
endmodule
